### sv/ole_pkg.sv
package ole_pkg;

  // Sizing of the list store.
  localparam int CAPACITY  = 32;
  localparam int TAG_BITS  = 16;
  localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_BITS  = $clog2(CAPACITY + 1);

  // Fixed widths of the request and result fields.
  localparam int OP_BITS     = 3;
  localparam int POS_BITS    = 6;
  localparam int CNT_BITS    = 6;
  localparam int TAGF_BITS   = 16;
  localparam int STATUS_BITS = 2;
  localparam int LEN_BITS    = 6;

  // Width used when a request field is compared with the occupancy.
  localparam int CMP_BITS = (OCC_BITS > POS_BITS) ? OCC_BITS : POS_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND     = 3'd0,
    OP_DELETE     = 3'd1,
    OP_MOVE_FRONT = 3'd2,
    OP_REVERSE    = 3'd3,
    OP_LENGTH     = 3'd4,
    OP_PRINT      = 3'd5
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_DEL_CHK,
    S_DEL_WR,
    S_MTF_GET,
    S_MTF_SAVE,
    S_MTF_CHK,
    S_MTF_WR,
    S_REV_RDI,
    S_REV_RDJ,
    S_REV_WRI,
    S_REV_WRJ,
    S_PRN_RD,
    S_PRN_OUT
  } state_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [POS_BITS-1:0]  position;
    logic [CNT_BITS-1:0]  count;
    logic [TAGF_BITS-1:0] tag;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [LEN_BITS-1:0]    list_length;
    logic [TAGF_BITS-1:0]   entry_tag;
    logic                   tag_valid;
    logic                   last;
  } out_rsp_t;

  // Request to and answer from the shared index unit.
  typedef struct packed {
    logic [OCC_BITS-1:0] idx;
    logic                down;
    logic [OCC_BITS-1:0] bound;
  } step_req_t;

  typedef struct packed {
    logic [OCC_BITS-1:0] next;
    logic                hit;
  } step_rsp_t;

endpackage

### sv/ole_ram.sv
module ole_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; the read data holds
  // until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/ole_step.sv
module ole_step (
  input  ole_pkg::step_req_t req,
  output ole_pkg::step_rsp_t rsp
);

  logic [ole_pkg::OCC_BITS-1:0] next;

  // Shared index unit: one step up or down and a compare of the new index.
  always_comb begin
    if (req.down) begin
      next = req.idx - 1'b1;
    end else begin
      next = req.idx + 1'b1;
    end
    rsp.next = next;
    rsp.hit  = (next == req.bound);
  end

endmodule

### sv/ordered_list_engine.sv
// Ordered list engine: keeps an ordered list of tags in a slot memory.
// A request on the in_ channel (in_valid, in_stall, in_data) names one
// operation: append, delete at position, move to front, reverse, length or
// print the first n entries. Results leave on the out_ channel (out_valid,
// out_stall, out_data), one per request, or one per printed entry with the
// final one marked by last.
// One request is worked on at a time: in_stall is high from acceptance until
// its last result is in the output register. Each moved entry takes a read
// and a write of the slot memory. Append, length, an empty print, a reversal
// of fewer than two entries and a bad position go straight to the result;
// the other cases first walk the entries that they move or print. While the
// receiver stalls, the output register holds its result and the sequencer
// waits before the next load. Reset empties the list and clears the output
// valid; the slot memory needs no clearing pass.
module ordered_list_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ole_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ole_pkg::out_rsp_t out_data
);

  ole_pkg::state_t               state_r, state_nxt;
  logic [ole_pkg::OCC_BITS-1:0]  occ_r, occ_nxt;
  logic [ole_pkg::OCC_BITS-1:0]  idx_r, idx_nxt;
  logic [ole_pkg::OCC_BITS-1:0]  jdx_r, jdx_nxt;
  logic [ole_pkg::OCC_BITS-1:0]  lim_r, lim_nxt;
  ole_pkg::status_t              status_r, status_nxt;
  logic                          done_r, done_nxt;
  logic [ole_pkg::TAG_BITS-1:0]  hold_r, hold_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ole_pkg::out_rsp_t             out_data_r, out_data_nxt;

  logic                          ram_we;
  logic [ole_pkg::ADDR_BITS-1:0] ram_waddr;
  logic [ole_pkg::TAG_BITS-1:0]  ram_wdata;
  logic                          ram_re;
  logic [ole_pkg::ADDR_BITS-1:0] ram_raddr;
  logic [ole_pkg::TAG_BITS-1:0]  ram_rdata;

  ole_pkg::step_req_t            step_req;
  ole_pkg::step_rsp_t            step_rsp;

  logic                          accept;
  logic                          out_free;
  logic [ole_pkg::CMP_BITS-1:0]  pos_w;
  logic [ole_pkg::CMP_BITS-1:0]  cnt_w;
  logic [ole_pkg::CMP_BITS-1:0]  occ_w;
  logic                          pos_bad;
  logic [ole_pkg::OCC_BITS-1:0]  prn_n;

  ole_ram #(
    .WIDTH (ole_pkg::TAG_BITS),
    .DEPTH (ole_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ole_step u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  // Handshake and request decoding.
  assign in_stall  = (state_r != ole_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_w   = ole_pkg::CMP_BITS'(in_data.position);
  assign cnt_w   = ole_pkg::CMP_BITS'(in_data.count);
  assign occ_w   = ole_pkg::CMP_BITS'(occ_r);
  assign pos_bad = (pos_w == '0) || (pos_w > occ_w);
  assign prn_n   = (cnt_w < occ_w) ? ole_pkg::OCC_BITS'(cnt_w) : occ_r;

  // Operand selection for the shared index unit.
  always_comb begin
    step_req.idx   = idx_r;
    step_req.down  = 1'b0;
    step_req.bound = lim_r;
    unique case (state_r)
      ole_pkg::S_IDLE: begin
        // Position minus one, or the last index for a reversal.
        if (ole_pkg::op_t'(in_data.operation) == ole_pkg::OP_REVERSE) begin
          step_req.idx = occ_r;
        end else begin
          step_req.idx = ole_pkg::OCC_BITS'(in_data.position);
        end
        step_req.down = 1'b1;
      end
      ole_pkg::S_DEL_CHK, ole_pkg::S_DEL_WR: begin
        step_req.bound = occ_r;
      end
      ole_pkg::S_MTF_CHK, ole_pkg::S_MTF_WR: begin
        step_req.down = 1'b1;
      end
      ole_pkg::S_REV_WRJ: begin
        step_req.idx  = jdx_r;
        step_req.down = 1'b1;
      end
      default: begin
        step_req.idx = idx_r;
      end
    endcase
  end

  // Sequencer: next state, memory control and result loading.
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    jdx_nxt       = jdx_r;
    lim_nxt       = lim_r;
    status_nxt    = status_r;
    done_nxt      = done_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[ole_pkg::ADDR_BITS-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[ole_pkg::ADDR_BITS-1:0];

    unique case (state_r)
      ole_pkg::S_IDLE: begin
        if (accept) begin
          status_nxt = ole_pkg::ST_OK;
          state_nxt  = ole_pkg::S_RESP;
          unique case (ole_pkg::op_t'(in_data.operation))
            ole_pkg::OP_APPEND: begin
              if (occ_r == ole_pkg::OCC_BITS'(ole_pkg::CAPACITY)) begin
                status_nxt = ole_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = occ_r[ole_pkg::ADDR_BITS-1:0];
                ram_wdata = ole_pkg::TAG_BITS'(in_data.tag);
                occ_nxt   = occ_r + 1'b1;
              end
            end
            ole_pkg::OP_DELETE: begin
              if (pos_bad) begin
                status_nxt = ole_pkg::ST_RANGE;
              end else begin
                idx_nxt   = step_rsp.next;
                state_nxt = ole_pkg::S_DEL_CHK;
              end
            end
            ole_pkg::OP_MOVE_FRONT: begin
              if (pos_bad) begin
                status_nxt = ole_pkg::ST_RANGE;
              end else begin
                idx_nxt   = step_rsp.next;
                state_nxt = ole_pkg::S_MTF_GET;
              end
            end
            ole_pkg::OP_REVERSE: begin
              if (occ_w >= ole_pkg::CMP_BITS'(2)) begin
                idx_nxt   = '0;
                jdx_nxt   = step_rsp.next;
                lim_nxt   = occ_r >> 1;
                state_nxt = ole_pkg::S_REV_RDI;
              end
            end
            ole_pkg::OP_PRINT: begin
              if (prn_n != '0) begin
                idx_nxt   = '0;
                lim_nxt   = prn_n;
                state_nxt = ole_pkg::S_PRN_RD;
              end
            end
            default: begin
              // Length and the unused codes only report the count.
              state_nxt = ole_pkg::S_RESP;
            end
          endcase
        end
      end

      ole_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.list_length = ole_pkg::LEN_BITS'(occ_r);
          out_data_nxt.entry_tag   = '0;
          out_data_nxt.tag_valid   = 1'b0;
          out_data_nxt.last        = 1'b1;
          state_nxt                = ole_pkg::S_IDLE;
        end
      end

      // Delete: pull each later entry one slot towards the head.
      ole_pkg::S_DEL_CHK: begin
        if (step_rsp.hit) begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = ole_pkg::S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = step_rsp.next[ole_pkg::ADDR_BITS-1:0];
          state_nxt = ole_pkg::S_DEL_WR;
        end
      end
      ole_pkg::S_DEL_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = step_rsp.next;
        state_nxt = ole_pkg::S_DEL_CHK;
      end

      // Move to front: keep the chosen entry, push the earlier ones down.
      ole_pkg::S_MTF_GET: begin
        ram_re    = 1'b1;
        state_nxt = ole_pkg::S_MTF_SAVE;
      end
      ole_pkg::S_MTF_SAVE: begin
        hold_nxt  = ram_rdata;
        state_nxt = ole_pkg::S_MTF_CHK;
      end
      ole_pkg::S_MTF_CHK: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = hold_r;
          state_nxt = ole_pkg::S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = step_rsp.next[ole_pkg::ADDR_BITS-1:0];
          state_nxt = ole_pkg::S_MTF_WR;
        end
      end
      ole_pkg::S_MTF_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = step_rsp.next;
        state_nxt = ole_pkg::S_MTF_CHK;
      end

      // Reverse: swap the entries at idx and jdx, moving both inwards.
      ole_pkg::S_REV_RDI: begin
        ram_re    = 1'b1;
        state_nxt = ole_pkg::S_REV_RDJ;
      end
      ole_pkg::S_REV_RDJ: begin
        hold_nxt  = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = jdx_r[ole_pkg::ADDR_BITS-1:0];
        state_nxt = ole_pkg::S_REV_WRI;
      end
      ole_pkg::S_REV_WRI: begin
        ram_we    = 1'b1;
        idx_nxt   = step_rsp.next;
        done_nxt  = step_rsp.hit;
        state_nxt = ole_pkg::S_REV_WRJ;
      end
      ole_pkg::S_REV_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_r[ole_pkg::ADDR_BITS-1:0];
        ram_wdata = hold_r;
        jdx_nxt   = step_rsp.next;
        state_nxt = done_r ? ole_pkg::S_RESP : ole_pkg::S_REV_RDI;
      end

      // Print: one read and one result per entry.
      ole_pkg::S_PRN_RD: begin
        ram_re    = 1'b1;
        state_nxt = ole_pkg::S_PRN_OUT;
      end
      ole_pkg::S_PRN_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ole_pkg::ST_OK;
          out_data_nxt.list_length = ole_pkg::LEN_BITS'(occ_r);
          out_data_nxt.entry_tag   = ole_pkg::TAGF_BITS'(ram_rdata);
          out_data_nxt.tag_valid   = 1'b1;
          out_data_nxt.last        = step_rsp.hit;
          idx_nxt                  = step_rsp.next;
          state_nxt = step_rsp.hit ? ole_pkg::S_IDLE : ole_pkg::S_PRN_RD;
        end
      end

      default: begin
        state_nxt = ole_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    jdx_r      <= jdx_nxt;
    lim_r      <= lim_nxt;
    status_r   <= status_nxt;
    done_r     <= done_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= ole_pkg::OCC_BITS'(ole_pkg::CAPACITY))
    else $error("list occupancy above capacity");

  // The count changes only on an append or at the end of a delete.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ole_pkg::S_IDLE && state_r != ole_pkg::S_DEL_CHK) |=> $stable(occ_r))
    else $error("list occupancy changed outside append or delete");

  // Apart from an append, writes land inside the occupied slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ole_pkg::S_IDLE) |-> (ole_pkg::OCC_BITS'(ram_waddr) < occ_r))
    else $error("slot write beyond the list");

  // While a reversal reads and writes its head entry, the head index stays below the tail index.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ole_pkg::S_REV_RDI || state_r == ole_pkg::S_REV_RDJ ||
     state_r == ole_pkg::S_REV_WRI) |-> (idx_r < jdx_r))
    else $error("reverse indices crossed");

  // Print never reads past the requested count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ole_pkg::S_PRN_OUT) |-> (idx_r < lim_r && lim_r <= occ_r))
    else $error("print index beyond count");

endmodule
